// ----- rtl/quaternion_trs_model_matrix_unit_defines.svh -----
// Assertion helpers for the TRS model matrix unit.
// The file using them must have clk_i and rst_ni in scope.
`ifndef QUATERNION_TRS_MODEL_MATRIX_UNIT_DEFINES_SVH
`define QUATERNION_TRS_MODEL_MATRIX_UNIT_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define QTRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when cond holds, prop holds in the next cycle.
`define QTRS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/qtrs_pkg.sv -----
package qtrs_pkg;

  localparam int unsigned PosW     = 32;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned QuatW    = 16;
  localparam int unsigned QuatFrac = 14;
  localparam int unsigned OutW     = 32;

  // Quaternion products are Q4.28; rotation entries need two more bits.
  localparam int unsigned QProdW   = 2 * QuatW;
  localparam int unsigned RotW     = QProdW + 2;
  localparam int unsigned MulW     = RotW + ScaleW;
  localparam int unsigned SumW     = MulW + 1;
  localparam int unsigned DropBits = 20;
  localparam int unsigned RndW     = SumW - DropBits;
  localparam int unsigned SatW     = ((RndW > OutW) ? RndW : OutW) + 1;

  localparam logic signed [RotW-1:0] RotOne  = RotW'(1) <<< (2 * QuatFrac);
  localparam logic signed [SumW-1:0] HalfLsb = SumW'(1) <<< (DropBits - 1);
  localparam logic signed [SatW-1:0] OutMax  =
    {{(SatW - OutW + 1){1'b0}}, {(OutW - 1){1'b1}}};
  localparam logic signed [SatW-1:0] OutMin  =
    {{(SatW - OutW + 1){1'b1}}, {(OutW - 1){1'b0}}};

  typedef struct packed {
    logic signed [PosW-1:0]   pos_x;
    logic signed [PosW-1:0]   pos_y;
    logic signed [PosW-1:0]   pos_z;
    logic signed [ScaleW-1:0] scale_x;
    logic signed [ScaleW-1:0] scale_y;
    logic signed [ScaleW-1:0] scale_z;
    logic signed [QuatW-1:0]  quat_x;
    logic signed [QuatW-1:0]  quat_y;
    logic signed [QuatW-1:0]  quat_z;
    logic signed [QuatW-1:0]  quat_w;
  } qtrs_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] m00;
    logic signed [OutW-1:0] m01;
    logic signed [OutW-1:0] m02;
    logic signed [OutW-1:0] m10;
    logic signed [OutW-1:0] m11;
    logic signed [OutW-1:0] m12;
    logic signed [OutW-1:0] m20;
    logic signed [OutW-1:0] m21;
    logic signed [OutW-1:0] m22;
    logic signed [OutW-1:0] t_x;
    logic signed [OutW-1:0] t_y;
    logic signed [OutW-1:0] t_z;
  } qtrs_out_t;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic signed [PosW-1:0] z;
  } qtrs_pos_t;

  // Load enables for the two stages inside each entry slice.
  typedef struct packed {
    logic mul_en;
    logic rnd_en;
  } qtrs_stage_en_t;

endpackage

// ----- rtl/qtrs_entry.sv -----
// One matrix entry: scale multiply, then round to nearest and saturate.
module qtrs_entry (
  input  logic                                 clk_i,
  input  qtrs_pkg::qtrs_stage_en_t             en_i,
  input  logic signed [qtrs_pkg::RotW-1:0]     rot_i,
  input  logic signed [qtrs_pkg::ScaleW-1:0]   scale_i,
  output logic signed [qtrs_pkg::OutW-1:0]     value_o
);

  logic signed [qtrs_pkg::MulW-1:0] prod_d, prod_q;
  logic signed [qtrs_pkg::SumW-1:0] biased;
  logic signed [qtrs_pkg::RndW-1:0] rnd;
  logic signed [qtrs_pkg::SatW-1:0] rnd_ext;
  logic signed [qtrs_pkg::OutW-1:0] value_d, value_q;

  assign prod_d = rot_i * scale_i;

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // ties go towards plus infinity: add half an lsb, floor shift
  assign biased  = qtrs_pkg::SumW'(prod_q) + qtrs_pkg::HalfLsb;
  assign rnd     = qtrs_pkg::RndW'(biased >>> qtrs_pkg::DropBits);
  assign rnd_ext = qtrs_pkg::SatW'(rnd);

  always_comb begin
    if (rnd_ext > qtrs_pkg::OutMax) begin
      value_d = qtrs_pkg::OutMax[qtrs_pkg::OutW-1:0];
    end else if (rnd_ext < qtrs_pkg::OutMin) begin
      value_d = qtrs_pkg::OutMin[qtrs_pkg::OutW-1:0];
    end else begin
      value_d = rnd_ext[qtrs_pkg::OutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.rnd_en) begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

// ----- rtl/quaternion_trs_model_matrix_unit.sv -----
// TRS model matrix unit.
// Takes a position, a per-axis scale and a rotation quaternion in one word and
// returns the upper three rows of T*R*S: nine Q16.16 rotation-scale entries,
// each rounded to nearest (ties upwards) and saturated, plus the translation.
// Input: a word is taken at a clock edge with start_i high and busy_o low.
// busy_o is held low, so a new word may be started on every cycle.
// Output: done_o is high for one cycle with result_o valid; the word is
// taken at the edge closing that cycle. The receiver has no hold-off.
// Each word passes through four pipeline registers on its way to result_o
// (quaternion products, rotation entries, scale products, round/saturate).
// Throughput: one word per cycle, set by the four-stage pipeline with one
// multiplier per product per stage.
// Reset (rst_ni low, asynchronous) drops every word in flight and clears
// done_o; datapath registers are not reset and only load behind a valid word.
// No normalisation of the quaternion is done.
`include "quaternion_trs_model_matrix_unit_defines.svh"

module quaternion_trs_model_matrix_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  qtrs_pkg::qtrs_in_t   in_i,
  output logic                 done_o,
  output qtrs_pkg::qtrs_out_t  result_o
);

  localparam int unsigned NumEnt = 9;

  // pipeline is never stalled
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // valid bits, one per stage
  logic s1_valid_q, s2_valid_q, s3_valid_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      done_q     <= s3_valid_q;
    end
  end

  // ---- stage 1: the nine quaternion products (Q4.28) ----
  logic signed [qtrs_pkg::QProdW-1:0] xx_q, xy_q, xz_q, xw_q, yy_q, yz_q, yw_q, zz_q, zw_q;
  logic signed [qtrs_pkg::ScaleW-1:0] s1_sx_q, s1_sy_q, s1_sz_q;
  qtrs_pkg::qtrs_pos_t                s1_pos_q, s2_pos_q, s3_pos_q, out_pos_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xx_q     <= in_i.quat_x * in_i.quat_x;
      xy_q     <= in_i.quat_x * in_i.quat_y;
      xz_q     <= in_i.quat_x * in_i.quat_z;
      xw_q     <= in_i.quat_x * in_i.quat_w;
      yy_q     <= in_i.quat_y * in_i.quat_y;
      yz_q     <= in_i.quat_y * in_i.quat_z;
      yw_q     <= in_i.quat_y * in_i.quat_w;
      zz_q     <= in_i.quat_z * in_i.quat_z;
      zw_q     <= in_i.quat_z * in_i.quat_w;
      s1_sx_q  <= in_i.scale_x;
      s1_sy_q  <= in_i.scale_y;
      s1_sz_q  <= in_i.scale_z;
      s1_pos_q <= '{x: in_i.pos_x, y: in_i.pos_y, z: in_i.pos_z};
    end
  end

  // ---- stage 2: rotation entries in units of 2^-28 ----
  logic signed [qtrs_pkg::RotW-1:0] exx, exy, exz, exw, eyy, eyz, eyw, ezz, ezw;
  logic signed [qtrs_pkg::RotW-1:0] rot_d [NumEnt];
  logic signed [qtrs_pkg::RotW-1:0] rot_q [NumEnt];
  logic signed [qtrs_pkg::ScaleW-1:0] s2_sx_q, s2_sy_q, s2_sz_q;
  logic signed [qtrs_pkg::ScaleW-1:0] col_scale [3];

  assign exx = qtrs_pkg::RotW'(xx_q);
  assign exy = qtrs_pkg::RotW'(xy_q);
  assign exz = qtrs_pkg::RotW'(xz_q);
  assign exw = qtrs_pkg::RotW'(xw_q);
  assign eyy = qtrs_pkg::RotW'(yy_q);
  assign eyz = qtrs_pkg::RotW'(yz_q);
  assign eyw = qtrs_pkg::RotW'(yw_q);
  assign ezz = qtrs_pkg::RotW'(zz_q);
  assign ezw = qtrs_pkg::RotW'(zw_q);

  // row-major order, m00 first
  assign rot_d[0] = qtrs_pkg::RotOne - ((eyy + ezz) <<< 1);
  assign rot_d[1] = (exy - ezw) <<< 1;
  assign rot_d[2] = (exz + eyw) <<< 1;
  assign rot_d[3] = (exy + ezw) <<< 1;
  assign rot_d[4] = qtrs_pkg::RotOne - ((exx + ezz) <<< 1);
  assign rot_d[5] = (eyz - exw) <<< 1;
  assign rot_d[6] = (exz - eyw) <<< 1;
  assign rot_d[7] = (eyz + exw) <<< 1;
  assign rot_d[8] = qtrs_pkg::RotOne - ((exx + eyy) <<< 1);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      rot_q    <= rot_d;
      s2_sx_q  <= s1_sx_q;
      s2_sy_q  <= s1_sy_q;
      s2_sz_q  <= s1_sz_q;
      s2_pos_q <= s1_pos_q;
    end
  end

  assign col_scale[0] = s2_sx_q;
  assign col_scale[1] = s2_sy_q;
  assign col_scale[2] = s2_sz_q;

  // ---- stages 3 and 4: scale multiply, round and saturate per entry ----
  qtrs_pkg::qtrs_stage_en_t         ent_en;
  logic signed [qtrs_pkg::OutW-1:0] ent_val [NumEnt];

  assign ent_en = '{mul_en: s2_valid_q, rnd_en: s3_valid_q};

  for (genvar k = 0; k < NumEnt; k++) begin : g_ent
    qtrs_entry u_entry (
      .clk_i   (clk_i),
      .en_i    (ent_en),
      .rot_i   (rot_q[k]),
      .scale_i (col_scale[k % 3]),
      .value_o (ent_val[k])
    );
  end

  // translation rides alongside the entries
  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      s3_pos_q <= s2_pos_q;
    end
    if (s3_valid_q) begin
      out_pos_q <= s3_pos_q;
    end
  end

  assign done_o       = done_q;
  assign result_o.m00 = ent_val[0];
  assign result_o.m01 = ent_val[1];
  assign result_o.m02 = ent_val[2];
  assign result_o.m10 = ent_val[3];
  assign result_o.m11 = ent_val[4];
  assign result_o.m12 = ent_val[5];
  assign result_o.m20 = ent_val[6];
  assign result_o.m21 = ent_val[7];
  assign result_o.m22 = ent_val[8];
  assign result_o.t_x = out_pos_q.x;
  assign result_o.t_y = out_pos_q.y;
  assign result_o.t_z = out_pos_q.z;

  // ---- checks ----
  `QTRS_ASSERT_NEXT(a_accept_enters, accept, s1_valid_q, "accepted word not in stage 1")
  `QTRS_ASSERT_NEXT(a_s2_to_done, s2_valid_q, ##1 done_o, "word lost after stage 2")
  `QTRS_ASSERT_NEXT(a_no_spurious, !s2_valid_q, ##1 !done_o, "result without a word")
  `QTRS_ASSERT(a_trans_match, done_o |-> (result_o.t_x == $past(s3_pos_q.x)),
               "translation out of step")
  `QTRS_ASSERT(a_never_busy, !busy_o, "pipeline reported busy")

endmodule

// ----- test/testbench.sv -----
module testbench;
  import qtrs_pkg::*;

  // Clock and reset
  logic clk    = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk = ~clk;

  // Block ports: every input is known from time zero
  logic      start_i = 1'b0;
  qtrs_in_t  in_i    = '0;
  logic      busy_o;
  logic      done_o;
  qtrs_out_t result_o;

  quaternion_trs_model_matrix_unit dut (
    .clk_i    (clk),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .in_i     (in_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // Fixed-point constants of the transform: unity rotation in Q4.28 units,
  // half an output LSB in the 2^-36 product units.
  localparam longint RotUnit  = longint'(1) <<< (2 * QuatFrac);
  localparam longint HalfUnit = longint'(1) <<< (DropBits - 1);
  localparam longint OutHi    = 64'sd2147483647;
  localparam longint OutLo    = -64'sd2147483648;

  qtrs_in_t  word_q[$];     // words waiting to be driven
  qtrs_out_t matrix_q[$];   // predicted matrices, oldest first
  int        words_taken = 0;
  int        mismatches  = 0;

  // Rotation entry (2^-28 units) times Q8.8 scale, rounded to Q16.16 with
  // ties towards plus infinity, then clamped to the signed 32-bit range.
  function automatic logic signed [OutW-1:0] scaled_entry(longint rot, longint scl);
    longint prod;
    longint q;
    prod = rot * scl;
    q = (prod + HalfUnit) >>> DropBits;
    if (q > OutHi) q = OutHi;
    if (q < OutLo) q = OutLo;
    return q[OutW-1:0];
  endfunction

  // Upper three rows of T*R*S for one word. No normalisation: the
  // quaternion is used exactly as it arrives.
  function automatic qtrs_out_t trs_matrix(qtrs_in_t w);
    qtrs_out_t m;
    longint x, y, z, q, sx, sy, sz;
    longint xx, xy, xz, xw, yy, yz, yw, zz, zw;
    x  = longint'(w.quat_x);
    y  = longint'(w.quat_y);
    z  = longint'(w.quat_z);
    q  = longint'(w.quat_w);
    sx = longint'(w.scale_x);
    sy = longint'(w.scale_y);
    sz = longint'(w.scale_z);
    xx = x * x; xy = x * y; xz = x * z; xw = x * q;
    yy = y * y; yz = y * z; yw = y * q;
    zz = z * z; zw = z * q;
    m.m00 = scaled_entry(RotUnit - 2 * (yy + zz), sx);
    m.m01 = scaled_entry(2 * (xy - zw), sy);
    m.m02 = scaled_entry(2 * (xz + yw), sz);
    m.m10 = scaled_entry(2 * (xy + zw), sx);
    m.m11 = scaled_entry(RotUnit - 2 * (xx + zz), sy);
    m.m12 = scaled_entry(2 * (yz - xw), sz);
    m.m20 = scaled_entry(2 * (xz - yw), sx);
    m.m21 = scaled_entry(2 * (yz + xw), sy);
    m.m22 = scaled_entry(RotUnit - 2 * (xx + yy), sz);
    m.t_x = w.pos_x;
    m.t_y = w.pos_y;
    m.t_z = w.pos_z;
    return m;
  endfunction

  task automatic check_field(input string name, input logic signed [OutW-1:0] want,
                             input logic signed [OutW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_word(input logic [PosW-1:0] px, py, pz,
                            input logic [ScaleW-1:0] sx, sy, sz,
                            input logic [QuatW-1:0] qx, qy, qz, qw);
    qtrs_in_t w;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz;
    w.scale_x = sx; w.scale_y = sy; w.scale_z = sz;
    w.quat_x = qx; w.quat_y = qy; w.quat_z = qz; w.quat_w = qw;
    word_q.push_back(w);
  endtask

  // 16-bit value biased towards the corners of the range
  function automatic logic [15:0] corner16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4: return 16'h0001;
      5: return 16'h4000;
      6: return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random word: unit-ish rotations with modest scales in four draws out of ten,
  // fully random bits in four and corner-heavy values in the other two.
  function automatic qtrs_in_t random_word();
    qtrs_in_t w;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    w.pos_x = $urandom;
    w.pos_y = $urandom;
    w.pos_z = $urandom;
    if (pick < 4) begin
      w.quat_x  = 16'($signed($urandom_range(0, 32768)) - 16384);
      w.quat_y  = 16'($signed($urandom_range(0, 32768)) - 16384);
      w.quat_z  = 16'($signed($urandom_range(0, 32768)) - 16384);
      w.quat_w  = 16'($signed($urandom_range(0, 32768)) - 16384);
      w.scale_x = 16'($signed($urandom_range(0, 2048)) - 1024);
      w.scale_y = 16'($signed($urandom_range(0, 2048)) - 1024);
      w.scale_z = 16'($signed($urandom_range(0, 2048)) - 1024);
    end else if (pick < 8) begin
      w.quat_x  = 16'($urandom); w.quat_y  = 16'($urandom);
      w.quat_z  = 16'($urandom); w.quat_w  = 16'($urandom);
      w.scale_x = 16'($urandom); w.scale_y = 16'($urandom);
      w.scale_z = 16'($urandom);
    end else begin
      w.quat_x  = corner16(); w.quat_y  = corner16();
      w.quat_z  = corner16(); w.quat_w  = corner16();
      w.scale_x = corner16(); w.scale_y = corner16();
      w.scale_z = corner16();
    end
    return w;
  endfunction

  // Driver: changes inputs on the falling edge. Holds start high across
  // back-to-back words (one assignment per edge). Idles with a chance of 19 in
  // 100, except for a long stretch of words driven with no gaps at all.
  always @(negedge clk) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (word_q.size() != 0 &&
                 ((words_taken >= 500 && words_taken < 800) ||
                  $urandom_range(0, 99) >= 19)) begin
      start_i <= 1'b1;
      in_i    <= word_q[0];
    end else begin
      // Idle cycle: junk on the data lines, which the block must ignore
      start_i <= 1'b0;
      in_i    <= qtrs_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom});
    end
  end

  // Monitor: samples on the rising edge. A word is taken when start is high
  // and busy low; its matrix is predicted at once. A result on done is
  // compared field by field against the oldest prediction.
  always @(posedge clk) begin
    qtrs_out_t want;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        matrix_q.push_back(trs_matrix(in_i));
        void'(word_q.pop_front());
        words_taken++;
      end
      if (done_o) begin
        if (matrix_q.size() == 0) begin
          $error("result with no word outstanding");
          mismatches++;
        end else begin
          want = matrix_q.pop_front();
          check_field("m00", want.m00, result_o.m00);
          check_field("m01", want.m01, result_o.m01);
          check_field("m02", want.m02, result_o.m02);
          check_field("m10", want.m10, result_o.m10);
          check_field("m11", want.m11, result_o.m11);
          check_field("m12", want.m12, result_o.m12);
          check_field("m20", want.m20, result_o.m20);
          check_field("m21", want.m21, result_o.m21);
          check_field("m22", want.m22, result_o.m22);
          check_field("t_x", want.t_x, result_o.t_x);
          check_field("t_y", want.t_y, result_o.t_y);
          check_field("t_z", want.t_z, result_o.t_z);
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    // Directed words first.
    // All zero: rotation diagonal is one, but zero scale kills it
    queue_word(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0);
    // Identity rotation, unit scale, simple translation
    queue_word(32'h0001_0000, 32'hffff_0000, 32'h0002_8000,
               16'h0100, 16'h0100, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h4000);
    // Translation extremes pass straight through
    queue_word(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
               16'h0100, 16'h0200, 16'hff00, 16'h0, 16'h0, 16'h0, 16'h4000);
    // Half-turns about each axis
    queue_word(32'h1, 32'h2, 32'h3, 16'h0100, 16'h0100, 16'h0100,
               16'h4000, 16'h0, 16'h0, 16'h0);
    queue_word(32'h4, 32'h5, 32'h6, 16'h0100, 16'h0100, 16'h0100,
               16'h0, 16'h4000, 16'h0, 16'h0);
    queue_word(32'h7, 32'h8, 32'h9, 16'h0100, 16'h0100, 16'h0100,
               16'h0, 16'h0, 16'h4000, 16'h0);
    // Most negative everything: largest magnitudes the products can take
    queue_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    // Most positive everything
    queue_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
               16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    // Mixed signs at the extremes, non-unit quaternion
    queue_word(32'h0, 32'hffff_ffff, 32'h7fff_ffff,
               16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    queue_word(32'hffff_ffff, 32'h0, 32'h8000_0000,
               16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    // Rounding ties: 2xy = 2^13 against scale 64 lands exactly on half an LSB,
    // upwards for positive scale and back to zero for negative
    queue_word(32'h0, 32'h0, 32'h0, 16'h0040, 16'h0040, 16'h0040,
               16'h0040, 16'h0040, 16'h0, 16'h0);
    queue_word(32'h0, 32'h0, 32'h0, 16'hffc0, 16'hffc0, 16'hffc0,
               16'h0040, 16'h0040, 16'h0, 16'h0);
    // Same tie with the sign carried by the quaternion
    queue_word(32'h0, 32'h0, 32'h0, 16'h0040, 16'h0040, 16'h0040,
               16'hffc0, 16'h0040, 16'h0, 16'h0);
    // Mirror: negative scale on one axis, 90 degrees about z
    queue_word(32'h0003_0000, 32'h0, 32'h0, 16'hff00, 16'h0100, 16'h0100,
               16'h0, 16'h0, 16'h2d41, 16'h2d41);
    // Tiny values, all ones
    queue_word(32'h1, 32'h1, 32'h1, 16'h0001, 16'h0001, 16'h0001,
               16'h0001, 16'h0001, 16'h0001, 16'h0001);
    queue_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
               16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

    repeat (1500) word_q.push_back(random_word());

    // Single reset at the start, released on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || matrix_q.size() != 0) @(posedge clk);
    // Let any stray result out of the four-stage pipe show itself
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("quaternion_trs_model_matrix_unit: match");
    end else begin
      $display("quaternion_trs_model_matrix_unit: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2000000;
    $display("quaternion_trs_model_matrix_unit: mismatch");
    $finish;
  end

endmodule
